>>> rtl/pctdec_pkg.sv
// shared types, constants and helpers of the percent decoder
package pctdec_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned NibbleW   = 4;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned NumCfgReg = 4;
  localparam int unsigned CfgIdxW   = $clog2(NumCfgReg);

  localparam logic [ByteW-1:0] PercentChar = 8'h25;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegIllegal0 = 2'd0;
  localparam logic [CfgIdxW-1:0] RegIllegal1 = 2'd1;
  localparam logic [CfgIdxW-1:0] RegIllegal2 = 2'd2;
  localparam logic [CfgIdxW-1:0] RegIllegal3 = 2'd3;

  typedef enum logic [1:0] {
    PhPlain = 2'd0,
    PhPercent = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } in_req_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             has_byte;
    logic             seg_end;
    logic             seg_error;
  } out_req_t;

  typedef struct packed {
    phase_e             phase;
    logic [NibbleW-1:0] high_nibble;
    logic               failed;
  } seg_state_t;

  localparam seg_state_t SegStateReset = '{phase: PhPlain, high_nibble: '0, failed: 1'b0};

  // hex digit decode: {valid, value}
  function automatic logic [NibbleW:0] hex_decode(input logic [ByteW-1:0] c);
    logic [NibbleW:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, NibbleW'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, NibbleW'(c - 8'h41 + 8'd10)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, NibbleW'(c - 8'h61 + 8'd10)};
    end
    return r;
  endfunction

endpackage

>>> rtl/percent_decoder_top.sv
// streaming percent decoder: input register, decode logic, result register
//
//   port group   dir  handshake              payload
//   in_*         in   in_valid_i/in_ready_o  in_req_i  (in_byte, in_last)
//   out_*        out  out_valid_o/out_ready_i out_req_o (out_byte, has_byte, seg_end, seg_error)
//   cfg_*        in   cfg_we_i               cfg_idx_i, cfg_data_i (illegal-byte bitmaps)
//
// one byte per cycle sustained while the output takes results; an accepted request
// passes the input register, then the decode logic into the result register.
// reset clears the segment state, the bitmaps and both valid flags.
// a waiting result stalls the decode stage only if that stage would produce a
// result itself; bytes that produce no result keep flowing.
module percent_decoder_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  pctdec_pkg::in_req_t                   in_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output pctdec_pkg::out_req_t                  out_req_o,
  input  logic                                  cfg_we_i,
  input  logic [pctdec_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pctdec_pkg::CfgW-1:0]           cfg_data_i
);
  import pctdec_pkg::*;

  logic [NumCfgReg-1:0][CfgW-1:0] illegal_q;
  logic                           in_valid_q;
  in_req_t                        in_req_q;
  seg_state_t                     seg_q, seg_d;
  logic                           out_valid_q;
  out_req_t                       out_req_q;
  logic                           res_valid;
  out_req_t                       res;
  logic                           stage_go;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      illegal_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegIllegal0: illegal_q[0] <= cfg_data_i;
        RegIllegal1: illegal_q[1] <= cfg_data_i;
        RegIllegal2: illegal_q[2] <= cfg_data_i;
        RegIllegal3: illegal_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // decode logic
  pctdec_step u_step (
    .cur_i       (seg_q),
    .req_i       (in_req_q),
    .illegal_i   (illegal_q),
    .nxt_o       (seg_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // stage advance and input handshake
  assign stage_go   = in_valid_q && (!res_valid || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || stage_go;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_req_q <= in_req_i;
    end
  end

  // segment state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q <= SegStateReset;
    end else if (stage_go) begin
      seg_q <= seg_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_go && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_go && res_valid) begin
      out_req_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule

>>> rtl/pctdec_step.sv
// next-state and result logic for one byte of the segment
module pctdec_step (
  input  pctdec_pkg::seg_state_t                 cur_i,
  input  pctdec_pkg::in_req_t                    req_i,
  input  logic [pctdec_pkg::NumCfgReg*pctdec_pkg::CfgW-1:0] illegal_i,
  output pctdec_pkg::seg_state_t                 nxt_o,
  output logic                                   res_valid_o,
  output pctdec_pkg::out_req_t                   res_o
);
  import pctdec_pkg::*;

  logic [NibbleW:0]  hex;
  logic [ByteW-1:0]  value;
  logic              have;
  seg_state_t        upd;

  assign hex = hex_decode(req_i.in_byte);

  // escape sequencing and error detection
  always_comb begin
    upd   = cur_i;
    have  = 1'b0;
    value = '0;
    if (!cur_i.failed) begin
      unique case (cur_i.phase)
        PhPercent: begin
          if (!hex[NibbleW]) begin
            upd.failed = 1'b1;
          end else begin
            upd.high_nibble = hex[NibbleW-1:0];
            upd.phase       = PhDigit;
          end
        end
        PhDigit: begin
          upd.phase = PhPlain;
          if (!hex[NibbleW]) begin
            upd.failed = 1'b1;
          end else begin
            value = {cur_i.high_nibble, hex[NibbleW-1:0]};
            if (value == '0 || illegal_i[value]) begin
              upd.failed = 1'b1;
            end else begin
              have = 1'b1;
            end
          end
        end
        default: begin
          upd.phase = PhPlain;
          if (req_i.in_byte == PercentChar) begin
            upd.phase = PhPercent;
          end else begin
            value = req_i.in_byte;
            have  = 1'b1;
          end
        end
      endcase
      if (req_i.in_last && upd.phase != PhPlain) begin
        upd.failed = 1'b1;
      end
    end
  end

  // result forming, state clears after the last byte
  always_comb begin
    res_o = '0;
    if (req_i.in_last) begin
      res_valid_o     = 1'b1;
      res_o.out_byte  = (!upd.failed && have) ? value : '0;
      res_o.has_byte  = !upd.failed && have;
      res_o.seg_end   = 1'b1;
      res_o.seg_error = upd.failed;
      nxt_o           = SegStateReset;
    end else begin
      res_valid_o    = have && !upd.failed;
      res_o.out_byte = value;
      res_o.has_byte = 1'b1;
      nxt_o          = upd;
    end
  end

endmodule
